// File: hw/rtl/tsc_pkg.sv
package tsc_pkg;

    localparam int NODE_COUNT    = 65536;
    localparam int ALPHABET_SIZE = 26;
    localparam int SLOT_COUNT    = NODE_COUNT * ALPHABET_SIZE;
    localparam int NODE_W        = $clog2(NODE_COUNT);
    localparam int LTR_W         = $clog2(ALPHABET_SIZE);
    localparam int SLOT_W        = $clog2(SLOT_COUNT);
    localparam int COUNT_W       = 32;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [LTR_W-1:0]   ltr_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    // one letter as seen by the back end
    typedef struct packed {
        logic first;
        op_t  op;
        ltr_t letter;
        logic last;
    } q_item_t;

    // node pool entry: the slot that points here, and the word count
    typedef struct packed {
        node_t  parent;
        ltr_t   letter;
        count_t count;
    } node_entry_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RD_CHILD,
        BK_CHK_NODE,
        BK_RESOLVE,
        BK_FINISH,
        BK_RESULT
    } back_state_t;

    localparam node_t  LAST_NODE = node_t'(NODE_COUNT - 1);
    localparam count_t COUNT_MAX = '1;

    function automatic slot_t slot_addr(node_t node, ltr_t ltr);
        slot_addr = SLOT_W'(node) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(ltr);
    endfunction

endpackage

// File: hw/rtl/tsc_front.sv
module tsc_front
    import tsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  logic    opcode,
    input  logic [4:0] letter,
    input  logic    last_letter,
    output logic    push,
    output q_item_t push_item,
    input  logic    q_full
);

    logic at_start_reg;
    logic at_start_next;
    op_t  word_op_reg;
    op_t  word_op_next;
    ltr_t ltr_clamped;

    assign req_ready = !q_full;
    assign push      = req_valid && !q_full;

    always_comb
    begin
        if (32'(letter) >= ALPHABET_SIZE)
            ltr_clamped = ltr_t'(ALPHABET_SIZE - 1);
        else
            ltr_clamped = ltr_t'(letter);
    end

    always_comb
    begin
        push_item.first  = at_start_reg;
        push_item.op     = at_start_reg ? op_t'(opcode) : word_op_reg;
        push_item.letter = ltr_clamped;
        push_item.last   = last_letter;
    end

    always_comb
    begin
        at_start_next = at_start_reg;
        word_op_next  = word_op_reg;
        if (push)
        begin
            at_start_next = last_letter;
            word_op_next  = push_item.op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg <= 1'b1;
            word_op_reg  <= OP_INSERT;
        end
        else
        begin
            at_start_reg <= at_start_next;
            word_op_reg  <= word_op_next;
        end
    end

endmodule

// File: hw/rtl/tsc_queue.sv
module tsc_queue
    import tsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    output logic    full,
    input  logic    pop,
    output logic    q_valid,
    output q_item_t q_item
);

    q_item_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg;
    logic [QCNT_W-1:0]  cnt_next;
    logic               do_pop;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: hw/rtl/tsc_back.sv
module tsc_back
    import tsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  q_item_t q_item,
    output logic    pop,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    output logic [31:0] word_count,
    output logic    status,
    output logic    was_insert
);

    back_state_t state_reg;
    back_state_t state_next;

    q_item_t     item_reg;
    q_item_t     item_next;
    node_t       cur_reg;
    node_t       cur_next;
    node_t       nf_reg;
    node_t       nf_next;
    logic        miss_reg;
    logic        miss_next;
    logic        exh_reg;
    logic        exh_next;
    slot_t       addr_reg;
    slot_t       addr_next;

    node_t       child_rd_reg;
    node_entry_t node_rd_reg;

    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    count_t      word_count_reg;
    count_t      word_count_next;
    logic        status_reg;
    logic        status_next;
    logic        was_insert_reg;
    logic        was_insert_next;

    // child pointers and node pool; no reset, entries are checked against
    // the allocation count and the back pointer of the node they name
    bit [NODE_W-1:0]              child_mem [SLOT_COUNT];
    bit [$bits(node_entry_t)-1:0] node_mem  [NODE_COUNT];

    node_t       start_node;
    logic        skip;
    logic        child_ok;
    logic        pool_left;
    logic        alloc;
    logic        out_free;
    logic        load_rsp;
    logic        cnt_we;
    node_t       new_node;
    node_t       node_raddr;
    logic        node_re;
    logic        node_we;
    node_t       node_waddr;
    node_entry_t node_wdata;
    count_t      count_inc;

    assign start_node = q_item.first ? '0 : cur_reg;
    assign skip       = !q_item.first &&
                        ((q_item.op == OP_INSERT) ? exh_reg : miss_reg);
    assign child_ok   = (child_rd_reg != '0) && (child_rd_reg <= nf_reg) &&
                        (node_rd_reg.parent == cur_reg) &&
                        (node_rd_reg.letter == item_reg.letter);
    assign pool_left  = (nf_reg != LAST_NODE);
    assign new_node   = nf_reg + 1'b1;
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign count_inc  = (node_rd_reg.count == COUNT_MAX) ? COUNT_MAX
                                                          : node_rd_reg.count + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                    state_next = skip ? BK_FINISH : BK_RD_CHILD;
            end
            BK_RD_CHILD: state_next = BK_CHK_NODE;
            BK_CHK_NODE: state_next = BK_RESOLVE;
            BK_RESOLVE:  state_next = BK_FINISH;
            BK_FINISH:   state_next = item_reg.last ? BK_RESULT : BK_IDLE;
            BK_RESULT:
            begin
                if (out_free)
                    state_next = BK_IDLE;
            end
            default:     state_next = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop        = 1'b0;
        alloc      = 1'b0;
        load_rsp   = 1'b0;
        cnt_we     = 1'b0;
        node_re    = 1'b0;
        node_raddr = cur_reg;
        case (state_reg)
            BK_IDLE:     pop = q_valid;
            BK_RD_CHILD:
            begin
                node_re = 1'b0;
            end
            BK_CHK_NODE:
            begin
                node_re    = 1'b1;
                node_raddr = child_rd_reg;
            end
            BK_RESOLVE:
                alloc = (item_reg.op == OP_INSERT) && !child_ok && pool_left;
            BK_FINISH:   node_re = item_reg.last;
            BK_RESULT:
            begin
                load_rsp = out_free;
                cnt_we   = out_free && (item_reg.op == OP_INSERT) && !exh_reg;
            end
            default:     pop = 1'b0;
        endcase
    end

    assign node_we    = alloc || cnt_we;
    assign node_waddr = alloc ? new_node : cur_reg;

    always_comb
    begin
        if (alloc)
        begin
            node_wdata.parent = cur_reg;
            node_wdata.letter = item_reg.letter;
            node_wdata.count  = '0;
        end
        else
        begin
            node_wdata       = node_rd_reg;
            node_wdata.count = count_inc;
        end
    end

    // walk state
    always_comb
    begin
        item_next = item_reg;
        cur_next  = cur_reg;
        nf_next   = nf_reg;
        miss_next = miss_reg;
        exh_next  = exh_reg;
        addr_next = addr_reg;
        if (pop)
        begin
            item_next = q_item;
            addr_next = slot_addr(start_node, q_item.letter);
            if (q_item.first)
            begin
                cur_next  = '0;
                miss_next = 1'b0;
                exh_next  = 1'b0;
            end
        end
        if (state_reg == BK_RESOLVE)
        begin
            if (child_ok)
                cur_next = child_rd_reg;
            else if (item_reg.op == OP_QUERY)
                miss_next = 1'b1;
            else if (pool_left)
            begin
                nf_next  = new_node;
                cur_next = new_node;
            end
            else
                exh_next = 1'b1;
        end
    end

    // result register
    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        word_count_next = word_count_reg;
        status_next     = status_reg;
        was_insert_next = was_insert_reg;
        if (load_rsp)
        begin
            rsp_valid_next  = 1'b1;
            was_insert_next = (item_reg.op == OP_INSERT);
            status_next     = (item_reg.op == OP_INSERT) && exh_reg;
            word_count_next = ((item_reg.op == OP_QUERY) && !miss_reg) ?
                              node_rd_reg.count : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cur_reg       <= '0;
            nf_reg        <= '0;
            miss_reg      <= 1'b0;
            exh_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            nf_reg        <= nf_next;
            miss_reg      <= miss_next;
            exh_reg       <= exh_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        addr_reg       <= addr_next;
        word_count_reg <= word_count_next;
        status_reg     <= status_next;
        was_insert_reg <= was_insert_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_RD_CHILD)
            child_rd_reg <= child_mem[addr_reg];
        if (alloc)
            child_mem[addr_reg] <= new_node;
    end

    always_ff @(posedge clk)
    begin
        if (node_re)
            node_rd_reg <= node_entry_t'(node_mem[node_raddr]);
        if (node_we)
            node_mem[node_waddr] <= node_wdata;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign word_count = word_count_reg;
    assign status     = status_reg;
    assign was_insert = was_insert_reg;

endmodule

// File: hw/rtl/trie_string_count_core.sv
// Word counter over a prefix tree held in a node pool.
// Request channel (req_valid/req_ready): one letter per item, with opcode
// (insert or query, taken at a word's first letter) and last_letter.
// Response channel (rsp_valid/rsp_ready): one item per word, on its last
// letter: word_count (query answer, zero on a miss or for an insert),
// status (pool full, insert dropped) and was_insert.
// Letters enter a two-entry queue; the walk engine behind it takes one
// letter at a time. Each letter passes through the child-table read, the
// node-pool check of the pointer read, then the update. Letters after a miss
// or a full pool skip these reads. The last letter adds a read-modify-write
// of its count; the response is then registered once the output is free.
// The engine takes no new letter before the last one is done, as the
// child-table then node-pool reads of each step depend on each other.
// Reset empties the tree at once: there is no clearing pass, since a child
// pointer counts only if it names an allocated node whose back pointer
// matches the slot. Reset also drops queued letters and any pending result.
// A stalled receiver holds the response; letters keep queueing until the
// queue is full, then req_ready falls.
module trie_string_count_core
    import tsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        opcode,
    input  logic [4:0]  letter,
    input  logic        last_letter,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [31:0] word_count,
    output logic        status,
    output logic        was_insert
);

    logic    push;
    q_item_t push_item;
    logic    q_full;
    logic    pop;
    logic    q_valid;
    q_item_t q_item;

    tsc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .opcode      (opcode),
        .letter      (letter),
        .last_letter (last_letter),
        .push        (push),
        .push_item   (push_item),
        .q_full      (q_full)
    );

    tsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    tsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .word_count (word_count),
        .status     (status),
        .was_insert (was_insert)
    );

endmodule

// File: hw/rtl/tsc_checker.sv
module tsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] word_count,
    input logic        status,
    input logic        was_insert
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            $stable(word_count) && $stable(status) && $stable(was_insert))
        else $error("response changed while stalled");

    a_insert_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && was_insert |-> word_count == 32'd0)
        else $error("insert ack carries a count");

    a_query_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !was_insert |-> !status)
        else $error("query answer flags pool full");

endmodule

bind trie_string_count_core tsc_checker u_tsc_checker (.*);
